[rtl/core/vpps_pkg.sv]
// ----------------------------------------------------------------------------
// vpps_pkg: shared types and constants of the pulse pattern sequencer
// Command codes, register indexes, reset values and the state, config and
// result bundles passed between the sequencer modules.
// ----------------------------------------------------------------------------
package vpps_pkg;

  localparam int CMD_W   = 2;
  localparam int CNT_W   = 8;
  localparam int TICK_W  = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_START  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CANCEL = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_PULSE_ON  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_GAP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SET_GAP   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN  = 2'd3;

  localparam logic [TICK_W-1:0] PULSE_ON_RST  = 16'd200;
  localparam logic [TICK_W-1:0] PULSE_GAP_RST = 16'd100;
  localparam logic [TICK_W-1:0] SET_GAP_RST   = 16'd500;
  localparam logic [TICK_W-1:0] COOLDOWN_RST  = 16'd1000;

  localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

  typedef struct packed {
    logic [TICK_W-1:0] pulse_on_ms;
    logic [TICK_W-1:0] pulse_gap_ms;
    logic [TICK_W-1:0] set_gap_ms;
    logic [TICK_W-1:0] cooldown_ms;
  } vpps_cfg_t;

  typedef struct packed {
    logic [CNT_W-1:0]  sets_left;
    logic [CNT_W-1:0]  pulses_per_set;
    logic [CNT_W-1:0]  pulses_left;
    logic              pulsing;
    logic              pausing;
    logic [TICK_W-1:0] elapsed;
    logic              led_restore;
    logic              motor;
    logic              led;
  } vpps_state_t;

  typedef struct packed {
    logic motor_on;
    logic led_on;
    logic busy_res;
  } vpps_res_t;

endpackage

[rtl/core/vpps_cfg.sv]
// ----------------------------------------------------------------------------
// vpps_cfg: timing register file
// Four 16-bit phase durations, written through the configuration channel.
// ----------------------------------------------------------------------------
module vpps_cfg
  import vpps_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [TICK_W-1:0]    wr_data,
  output vpps_cfg_t            cfg
);

  vpps_cfg_t cfg_r;
  vpps_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        REG_PULSE_ON:  cfg_nxt.pulse_on_ms  = wr_data;
        REG_PULSE_GAP: cfg_nxt.pulse_gap_ms = wr_data;
        REG_SET_GAP:   cfg_nxt.set_gap_ms   = wr_data;
        REG_COOLDOWN:  cfg_nxt.cooldown_ms  = wr_data;
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pulse_on_ms  <= PULSE_ON_RST;
      cfg_r.pulse_gap_ms <= PULSE_GAP_RST;
      cfg_r.set_gap_ms   <= SET_GAP_RST;
      cfg_r.cooldown_ms  <= COOLDOWN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[rtl/core/vpps_step.sv]
// ----------------------------------------------------------------------------
// vpps_step: sequencer state and its one-item update
// Holds the pattern state and applies a tick, start or cancel on each fired beat.
// ----------------------------------------------------------------------------
module vpps_step
  import vpps_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic [CMD_W-1:0]  cmd,
  input  logic [CNT_W-1:0]  set_count,
  input  logic [CNT_W-1:0]  pulse_count,
  input  logic              led_level_now,
  input  vpps_cfg_t         cfg,
  output vpps_res_t         res
);

  vpps_state_t st_r;
  vpps_state_t st_nxt;
  logic [TICK_W-1:0] limit;
  logic busy_now;

  assign busy_now = (st_r.sets_left != '0) || (st_r.pulses_per_set != '0);

  always_comb begin
    st_nxt = st_r;
    limit  = '0;
    unique case (cmd)
      CMD_TICK: begin
        if (st_r.elapsed != TICK_MAX) begin
          st_nxt.elapsed = st_r.elapsed + 1'b1;
        end
        if (st_r.pulses_left != '0) begin
          if (st_r.pulsing) begin
            if (st_nxt.elapsed >= cfg.pulse_on_ms) begin
              st_nxt.pulsing     = 1'b0;
              st_nxt.pulses_left = st_r.pulses_left - 1'b1;
              st_nxt.elapsed     = '0;
              st_nxt.motor       = 1'b0;
              st_nxt.led         = 1'b0;
              if (st_r.pulses_left == CNT_W'(1)) begin
                st_nxt.pausing = 1'b1;
                if (st_r.sets_left == '0) begin
                  st_nxt.led = st_r.led_restore;
                end
              end
            end
          end else if (st_nxt.elapsed >= cfg.pulse_gap_ms) begin
            st_nxt.pulsing = 1'b1;
            st_nxt.elapsed = '0;
            st_nxt.motor   = 1'b1;
            st_nxt.led     = 1'b1;
          end
        end else if (st_r.pausing) begin
          limit = (st_r.sets_left != '0) ? cfg.set_gap_ms : cfg.cooldown_ms;
          if (st_nxt.elapsed >= limit) begin
            st_nxt.pausing = 1'b0;
          end
        end else if (st_r.sets_left != '0) begin
          st_nxt.sets_left   = st_r.sets_left - 1'b1;
          st_nxt.pulsing     = 1'b1;
          st_nxt.pulses_left = st_r.pulses_per_set;
          st_nxt.elapsed     = '0;
          st_nxt.motor       = 1'b1;
          st_nxt.led         = 1'b1;
        end else begin
          st_nxt.sets_left      = '0;
          st_nxt.pulses_per_set = '0;
          st_nxt.pulses_left    = '0;
          st_nxt.pulsing        = 1'b0;
        end
      end
      CMD_START: begin
        if (!busy_now && set_count != '0 && pulse_count != '0) begin
          st_nxt.led_restore    = led_level_now;
          st_nxt.sets_left      = set_count;
          st_nxt.pulses_per_set = pulse_count;
          st_nxt.pulses_left    = '0;
          st_nxt.pulsing        = 1'b0;
          st_nxt.pausing        = 1'b0;
        end
      end
      CMD_CANCEL: begin
        if (busy_now) begin
          st_nxt.sets_left      = '0;
          st_nxt.pulses_per_set = '0;
          st_nxt.pulses_left    = '0;
          st_nxt.pulsing        = 1'b0;
          st_nxt.pausing        = 1'b0;
          st_nxt.motor          = 1'b0;
          st_nxt.led            = st_r.led_restore;
        end
      end
      default: st_nxt = st_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (fire) begin
      st_r <= st_nxt;
    end
  end

  assign res.motor_on = st_nxt.motor;
  assign res.led_on   = st_nxt.led;
  assign res.busy_res = (st_nxt.sets_left != '0) || (st_nxt.pulses_per_set != '0);

  // The motor only runs inside a pulse, and a pulse always has pulses left.
  a_motor_in_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.motor |-> st_r.pulsing)
    else $error("motor on outside a pulse");

  a_pulse_has_count: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.pulsing |-> (st_r.pulses_left != '0))
    else $error("pulsing with no pulses left");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.sets_left == '0 && st_r.pulses_per_set == '0) |-> !st_r.pulsing)
    else $error("pulsing while idle");

endmodule

[rtl/core/vibration_pulse_pattern_sequencer_unit.sv]
// ----------------------------------------------------------------------------
// vibration_pulse_pattern_sequencer_unit: motor and LED pulse pattern driver
// Top level: input register, sequencer state update, result register.
// ----------------------------------------------------------------------------
// Usage:
//   Each input beat is a one-millisecond tick, a start request (set count,
//   pulse count, current LED level) or a cancel. Every input beat yields
//   exactly one result beat with motor level, LED level and busy flag as
//   they stand after that beat.
//   The configuration channel writes the four phase durations (index 0..3:
//   pulse on, pulse gap, set gap, cooldown); it is always ready and is
//   meant to be written only while the pattern is idle.
//   An accepted beat lands in the input register, and its result is
//   registered in the result register, which drives out_valid, when the
//   beat fires. Throughput is one beat per cycle while the receiver does
//   not stall, set by the state update between the two registers.
//   Reset clears the pattern state to idle, empties both registers and
//   loads the default durations (200, 100, 500, 1000).
//   When the receiver stalls, the result register holds; the input register
//   still takes one more beat if it is empty, after which in_stall rises until the result
//   is taken.
// ----------------------------------------------------------------------------
module vibration_pulse_pattern_sequencer_unit
  import vpps_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [CMD_W-1:0]     in_cmd,
  input  logic [CNT_W-1:0]     in_set_count,
  input  logic [CNT_W-1:0]     in_pulse_count,
  input  logic                 in_led_level_now,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_motor_on,
  output logic                 out_led_on,
  output logic                 out_busy_res,
  // configuration channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TICK_W-1:0]    cfg_data
);

  vpps_cfg_t cfg;
  vpps_res_t res;

  logic             in_vld_r;
  logic [CMD_W-1:0] cmd_r;
  logic [CNT_W-1:0] set_count_r;
  logic [CNT_W-1:0] pulse_count_r;
  logic             led_now_r;

  logic      out_vld_r;
  vpps_res_t res_r;

  logic hold;
  logic fire;

  // Hold the pipeline while a finished result waits on a stalled receiver.
  assign hold     = out_vld_r && out_stall;
  assign fire     = in_vld_r && !hold;
  assign in_stall = in_vld_r && hold;
  assign cfg_ready = 1'b1;

  vpps_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  vpps_step u_step (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (fire),
    .cmd           (cmd_r),
    .set_count     (set_count_r),
    .pulse_count   (pulse_count_r),
    .led_level_now (led_now_r),
    .cfg           (cfg),
    .res           (res)
  );

  // Input register: refill whenever it is empty or its beat moves on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      cmd_r         <= in_cmd;
      set_count_r   <= in_set_count;
      pulse_count_r <= in_pulse_count;
      led_now_r     <= in_led_level_now;
    end
  end

  // Result register: load on fire, drop once the receiver takes the beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_valid    = out_vld_r;
  assign out_motor_on = res_r.motor_on;
  assign out_led_on   = res_r.led_on;
  assign out_busy_res = res_r.busy_res;

  // A beat leaving the input register always lands in the result register.
  a_fire_lands: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_vld_r)
    else $error("processed beat did not reach the result register");

  // Back-pressure on the input only while both registers are full.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_vld_r && out_vld_r))
    else $error("input stalled with a free register");

  // A held input beat is not processed.
  a_hold_no_fire: assert property (@(posedge clk) disable iff (!rst_n)
    hold |-> !fire)
    else $error("beat processed while result held");

endmodule
